// ===== rtl/mfb_pkg.sv =====
// Package for the packed one-bit-per-pixel framebuffer: codes, widths, state type and helpers.
package mfb_pkg;

	// Default screen size in pixels.
	localparam int DEF_SCREEN_WIDTH  = 256;
	localparam int DEF_SCREEN_HEIGHT = 127;

	// Field widths of a request and the internal coordinate widths.
	localparam int COORD_W = 10;
	localparam int CUR_W   = COORD_W + 1;
	localparam int PIX_W   = 2 * COORD_W + 1;
	localparam int FUNC_W  = 3;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_WRITE_PIXEL = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ_PIXEL  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FILL_RECT   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_INVERT_RECT = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ_ROW    = 3'd4;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MODIFY
	} state_t;

	// Byte mask with bits lo through hi set, where lo <= hi.
	function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
		logic [7:0] m;
		m = (8'hff << lo) & (8'hff >> (3'd7 - hi));
		return m;
	endfunction

endpackage

// ===== rtl/mono_framebuffer_raster_engine.sv =====
// Top level of the packed one-bit-per-pixel framebuffer with its byte store and sequencer.
//
// Usage:
//   The request channel (in_valid, in_stall) carries one operation: write pixel,
//   read pixel, fill rectangle, invert rectangle or read row. The result channel
//   (out_valid, out_stall) returns one byte for a pixel read, or one packed byte
//   per eight pixels for a row read, with last_of_run on the final byte.
//   Requests are taken only while the sequencer is idle; a finished result sits
//   in the output register, so the next request may be taken while it waits.
// Sequence:
//   A request is taken in the idle state. Each byte segment it touches is then
//   fetched from the byte store in a read state and handled in a modify state,
//   which writes it back for a pixel write, fill or invert. A row read walks one
//   segment per store byte and aligned group of eight pixels, so when the screen
//   width is not a multiple of eight a result byte may take two segments.
// Reset and stall:
//   After reset the store is cleared by a pass of one byte per cycle; no request
//   is taken meanwhile.
//   When the receiver stalls with a result pending, the sequencer holds at the
//   next byte that needs the output register and resumes once it is free.
module mono_framebuffer_raster_engine
	import mfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [FUNC_W-1:0]  func,
	input  logic [COORD_W-1:0] left_x,
	input  logic [COORD_W-1:0] top_y,
	input  logic [COORD_W-1:0] right_x,
	input  logic [COORD_W-1:0] bottom_y,
	input  logic               ink,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_data,
	output logic               last_of_run
);

	localparam int STORE_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam logic [CUR_W-1:0] WIDTH_C  = CUR_W'(SCREEN_WIDTH);
	localparam logic [CUR_W-1:0] HEIGHT_C = CUR_W'(SCREEN_HEIGHT);
	localparam logic [PIX_W-1:0] WIDTH_P  = PIX_W'(SCREEN_WIDTH);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_BYTES - 1);

	// Byte store.
	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_data_q;
	logic       mem_re;
	logic       mem_we;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	// Sequencer state and operation registers.
	state_t state_q, state_d;
	logic [AW-1:0]    clr_addr_q;
	logic [FUNC_W-1:0] func_q;
	logic             ink_q;
	logic             skip_q;
	logic [CUR_W-1:0] x_q, xs_q, xe_q;
	logic [CUR_W-1:0] y_q, ye_q;
	logic [PIX_W-1:0] rowbase_q;
	logic [CUR_W-1:0] seg_end_q;
	logic [7:0]       seg_mask_q;
	logic [AW-1:0]    addr_q;
	logic [7:0]       acc_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	// Request decode.
	logic [CUR_W-1:0] x0, y0, x1, y1;
	logic             on0, on1;
	logic             s_go, s_skip;
	logic [CUR_W-1:0] s_xs, s_xe, s_ys, s_ye;
	logic [CUR_W-1:0] fill_xe, fill_ye;

	// Segment math.
	logic [PIX_W-1:0] pix;
	logic [2:0]       pix_off;
	logic [CUR_W-1:0] end_a, end_b, end_c, seg_end;

	// Control from the sequencer.
	logic             accept_in;
	logic             clr_last;
	logic             out_free;
	logic             is_store_op;
	logic             is_row;
	logic             need_emit;
	logic             byte_done;
	logic             row_done;
	logic             op_done;
	logic             step;
	logic [7:0]       data_eff;
	logic [7:0]       picked;
	logic [CUR_W-1:0] nx;

	// Decode a request into a clipped walk range.
	always_comb begin
		x0 = {1'b0, left_x};
		y0 = {1'b0, top_y};
		x1 = {1'b0, right_x};
		y1 = {1'b0, bottom_y};
		on0 = (x0 < WIDTH_C) && (y0 < HEIGHT_C);
		on1 = (x1 < WIDTH_C) && (y1 < HEIGHT_C);
		fill_xe = (x1 < WIDTH_C) ? x1 : WIDTH_C;
		fill_ye = (y1 < HEIGHT_C) ? y1 : HEIGHT_C;
		s_go   = 1'b0;
		s_skip = 1'b0;
		s_xs   = x0;
		s_xe   = x0 + CUR_W'(1);
		s_ys   = y0;
		s_ye   = y0 + CUR_W'(1);
		case (func)
			FUNC_WRITE_PIXEL: begin
				s_go = on0;
			end
			FUNC_READ_PIXEL: begin
				s_go   = 1'b1;
				s_skip = !on0;
			end
			FUNC_FILL_RECT: begin
				s_xe = fill_xe;
				s_ye = fill_ye;
				s_go = (x0 < fill_xe) && (y0 < fill_ye);
			end
			FUNC_INVERT_RECT: begin
				s_xe = x1;
				s_ye = y1;
				s_go = on0 && on1 && (x0 < x1) && (y0 < y1);
			end
			FUNC_READ_ROW: begin
				s_xs   = '0;
				s_xe   = WIDTH_C;
				s_go   = 1'b1;
				s_skip = !(y0 < HEIGHT_C);
			end
			default: begin
				s_go = 1'b0;
			end
		endcase
	end

	// Current segment: stays inside one store byte and one aligned group of eight x.
	always_comb begin
		pix     = rowbase_q + PIX_W'(x_q);
		pix_off = pix[2:0];
		end_a   = x_q + CUR_W'(3'd7 - pix_off);
		end_b   = x_q | CUR_W'(7);
		end_c   = xe_q - CUR_W'(1);
		seg_end = end_a;
		if (end_b < seg_end) begin
			seg_end = end_b;
		end
		if (end_c < seg_end) begin
			seg_end = end_c;
		end
	end

	// Modify step: bits of the fetched byte, byte completion and walk advance.
	always_comb begin
		out_free    = !out_valid_q || !out_stall;
		is_store_op = (func_q == FUNC_WRITE_PIXEL) || (func_q == FUNC_FILL_RECT) ||
			(func_q == FUNC_INVERT_RECT);
		is_row      = (func_q == FUNC_READ_ROW);
		data_eff    = skip_q ? 8'h00 : rd_data_q;
		picked      = data_eff & seg_mask_q;
		nx          = seg_end_q + CUR_W'(1);
		row_done    = (nx == xe_q);
		op_done     = row_done && ((y_q + CUR_W'(1)) == ye_q);
		byte_done   = (seg_end_q[2:0] == 3'd7) || row_done;
		need_emit   = (func_q == FUNC_READ_PIXEL) || (is_row && byte_done);
		clr_last    = (clr_addr_q == LAST_ADDR);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && s_go) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				if (!need_emit || out_free) begin
					state_d = op_done ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		accept_in = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = pix[AW+2:3];
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = rd_data_q;
		step      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = 8'h00;
			end
			ST_IDLE: begin
				in_stall  = 1'b0;
				accept_in = in_valid;
			end
			ST_READ: begin
				mem_re = !skip_q;
			end
			ST_MODIFY: begin
				step = !need_emit || out_free;
				if (is_store_op) begin
					mem_we = 1'b1;
					if (func_q == FUNC_INVERT_RECT) begin
						mem_wdata = rd_data_q ^ seg_mask_q;
					end else if (ink_q) begin
						mem_wdata = rd_data_q | seg_mask_q;
					end else begin
						mem_wdata = rd_data_q & ~seg_mask_q;
					end
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (step && need_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk and result registers.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_q    <= func;
			ink_q     <= ink;
			skip_q    <= s_skip;
			x_q       <= s_xs;
			xs_q      <= s_xs;
			xe_q      <= s_xe;
			y_q       <= s_ys;
			ye_q      <= s_ye;
			rowbase_q <= WIDTH_P * PIX_W'(top_y);
			acc_q     <= 8'h00;
		end
		if (state_q == ST_READ) begin
			seg_end_q  <= seg_end;
			seg_mask_q <= span_mask(x_q[2:0], seg_end[2:0]);
			addr_q     <= pix[AW+2:3];
		end
		if (step) begin
			if (row_done) begin
				x_q       <= xs_q;
				y_q       <= y_q + CUR_W'(1);
				rowbase_q <= rowbase_q + WIDTH_P;
			end else begin
				x_q <= nx;
			end
			if (is_row) begin
				acc_q <= byte_done ? 8'h00 : (acc_q | picked);
			end
			if (need_emit) begin
				out_data_q <= is_row ? (acc_q | picked) : ((picked != 8'h00) ? 8'hff : 8'h00);
				out_last_q <= op_done;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign last_of_run = out_last_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the packed one-bit-per-pixel framebuffer raster engine.
module testbench;
	import mfb_pkg::*;

	localparam int SCREEN_W        = DEF_SCREEN_WIDTH;
	localparam int SCREEN_H        = DEF_SCREEN_HEIGHT;
	localparam int STORE_BYTES     = (SCREEN_W * SCREEN_H + 7) / 8;
	localparam int ROW_BYTES       = (SCREEN_W + 7) / 8;
	localparam int COORD_MAX       = (1 << COORD_W) - 1;
	localparam int FUNC_MAX        = (1 << FUNC_W) - 1;
	localparam int RANDOM_REQUESTS = 68;
	localparam int PHASES          = 4;
	localparam int DRAIN_CYCLES    = 200;

	// One byte that a pixel read or a row read should return.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} read_byte_t;

	// Shadow copy of the pixel store plus the bytes still owed by the block.
	class fb_scoreboard;
		logic [7:0] pixel_bytes [STORE_BYTES];
		read_byte_t pending_reads [$];
		int         results_checked;
		int         errors;

		function new();
			foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
			results_checked = 0;
			errors = 0;
		endfunction

		function bit on_screen(int x, int y);
			return x < SCREEN_W && y < SCREEN_H;
		endfunction

		function bit pixel_at(int x, int y);
			if (!on_screen(x, y)) return 1'b0;
			return pixel_bytes[(x + SCREEN_W * y) >> 3][x & 7];
		endfunction

		function void put_pixel(int x, int y, bit v);
			if (on_screen(x, y)) pixel_bytes[(x + SCREEN_W * y) >> 3][x & 7] = v;
		endfunction

		// Apply one accepted request to the shadow store and queue its read bytes.
		function void note_request(logic [FUNC_W-1:0] f, int x0, int y0, int x1, int y1,
				bit k);
			read_byte_t r;
			case (f)
			FUNC_WRITE_PIXEL: begin
				put_pixel(x0, y0, k);
			end
			FUNC_READ_PIXEL: begin
				r.data = pixel_at(x0, y0) ? 8'hff : 8'h00;
				r.last = 1'b1;
				pending_reads.push_back(r);
			end
			FUNC_FILL_RECT: begin
				// Pixels off screen are simply skipped, so the loops stop at the edges.
				for (int y = y0; y < y1 && y < SCREEN_H; y++)
					for (int x = x0; x < x1 && x < SCREEN_W; x++)
						put_pixel(x, y, k);
			end
			FUNC_INVERT_RECT: begin
				// Any corner off screen cancels the whole invert.
				if (on_screen(x0, y0) && on_screen(x1, y1))
					for (int y = y0; y < y1; y++)
						for (int x = x0; x < x1; x++)
							put_pixel(x, y, !pixel_at(x, y));
			end
			FUNC_READ_ROW: begin
				for (int b = 0; b < ROW_BYTES; b++) begin
					for (int i = 0; i < 8; i++)
						r.data[i] = pixel_at(8 * b + i, y0);
					r.last = (b == ROW_BYTES - 1);
					pending_reads.push_back(r);
				end
			end
			default: begin
			end
			endcase
		endfunction

		// Compare one returned byte with the oldest outstanding one.
		function void check_result(logic [7:0] data, logic last);
			read_byte_t r;
			results_checked++;
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected result: read_data=%02h last_of_run=%0b",
					$time, data, last);
				errors++;
				return;
			end
			r = pending_reads.pop_front();
			if (data !== r.data) begin
				$display("%0t: read_data mismatch: expected %02h, actual %02h",
					$time, r.data, data);
				errors++;
			end
			if (last !== r.last) begin
				$display("%0t: last_of_run mismatch: expected %0b, actual %0b",
					$time, r.last, last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [FUNC_W-1:0]  func;
	logic [COORD_W-1:0] left_x;
	logic [COORD_W-1:0] top_y;
	logic [COORD_W-1:0] right_x;
	logic [COORD_W-1:0] bottom_y;
	logic               ink;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         read_data;
	logic               last_of_run;

	fb_scoreboard sb;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           requests_by_func [FUNC_MAX + 1];

	mono_framebuffer_raster_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.left_x      (left_x),
		.top_y       (top_y),
		.right_x     (right_x),
		.bottom_y    (bottom_y),
		.ink         (ink),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.last_of_run (last_of_run)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check every result taken by the receiver.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(read_data, last_of_run);
	end

	// Present one request, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_request(input logic [FUNC_W-1:0] f, input int x0, input int y0,
			input int x1, input int y1, input bit k);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		left_x   <= x0[COORD_W-1:0];
		top_y    <= y0[COORD_W-1:0];
		right_x  <= x1[COORD_W-1:0];
		bottom_y <= y1[COORD_W-1:0];
		ink      <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(f, x0, y0, x1, y1, k);
		requests_by_func[f]++;
	endtask

	task automatic wait_reads_done();
		while (sb.pending_reads.size() != 0) @(posedge clk);
	endtask

	// Mostly on screen, some near the edges, a few anywhere in the field's range.
	function automatic int pick_x();
		int r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(0, SCREEN_W - 1);
		if (r < 90) return $urandom_range(SCREEN_W - 8, SCREEN_W + 7);
		return $urandom_range(0, COORD_MAX);
	endfunction

	function automatic int pick_y();
		int r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(0, SCREEN_H - 1);
		if (r < 90) return $urandom_range(SCREEN_H - 7, SCREEN_H + 6);
		return $urandom_range(0, COORD_MAX);
	endfunction

	function automatic int clamp_coord(int v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	// Random mix of all operations; rectangles stay small in at least one direction.
	task automatic run_random(input int count);
		int               r;
		int               x0;
		int               y0;
		int               x1;
		int               y1;
		logic [FUNC_W-1:0] f;
		for (int n = 0; n < count; n++) begin
			// An occasional unused code that the block ignores.
			if ($urandom_range(99) < 5)
				send_request(FUNC_W'($urandom_range(FUNC_READ_ROW + 1, FUNC_MAX)),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					1'($urandom_range(1)));
			r = $urandom_range(99);
			if (r < 30) f = FUNC_WRITE_PIXEL;
			else if (r < 50) f = FUNC_READ_PIXEL;
			else if (r < 70) f = FUNC_FILL_RECT;
			else if (r < 85) f = FUNC_INVERT_RECT;
			else f = FUNC_READ_ROW;
			x0 = pick_x();
			y0 = pick_y();
			x1 = $urandom_range(0, COORD_MAX);
			y1 = $urandom_range(0, COORD_MAX);
			if (f == FUNC_FILL_RECT || f == FUNC_INVERT_RECT) begin
				r = $urandom_range(99);
				x1 = clamp_coord(x0 + $urandom_range(0, 20));
				y1 = clamp_coord(y0 + $urandom_range(0, 6));
				if (r < 7) x1 = $urandom_range(0, COORD_MAX);
				else if (r < 14) y1 = $urandom_range(0, COORD_MAX);
			end
			send_request(f, x0, y0, x1, y1, 1'($urandom_range(1)));
		end
	endtask

	// Reset, directed cases, random phases, then drain and report.
	initial begin
		sb = new();
		foreach (requests_by_func[i]) requests_by_func[i] = 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		func     <= FUNC_WRITE_PIXEL;
		left_x   <= '0;
		top_y    <= '0;
		right_x  <= '0;
		bottom_y <= '0;
		ink      <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Pixel writes at the corners and just off screen.
		send_request(FUNC_WRITE_PIXEL, 0, 0, 0, 0, 1'b1);
		send_request(FUNC_WRITE_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 1'b1);
		send_request(FUNC_WRITE_PIXEL, SCREEN_W, 0, 0, 0, 1'b1);
		send_request(FUNC_WRITE_PIXEL, 0, SCREEN_H, 0, 0, 1'b1);
		send_request(FUNC_WRITE_PIXEL, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		// Pixel reads on and off screen.
		send_request(FUNC_READ_PIXEL, 0, 0, 0, 0, 1'b0);
		send_request(FUNC_READ_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 1'b0);
		send_request(FUNC_READ_PIXEL, SCREEN_W, 0, 0, 0, 1'b0);
		send_request(FUNC_READ_PIXEL, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		send_request(FUNC_READ_ROW, 0, 0, 0, 0, 1'b0);
		send_request(FUNC_READ_ROW, 0, SCREEN_H - 1, 0, 0, 1'b0);
		// Fills: partial bytes, clipped at the edges, and empty rectangles.
		send_request(FUNC_FILL_RECT, 3, 10, 21, 13, 1'b1);
		send_request(FUNC_FILL_RECT, SCREEN_W - 6, SCREEN_H - 7, SCREEN_W + 14,
			SCREEN_H + 8, 1'b1);
		send_request(FUNC_FILL_RECT, 20, 5, 20, 9, 1'b1);
		send_request(FUNC_FILL_RECT, 30, 9, 10, 9, 1'b1);
		// Inverts: a normal one, two that the corner guard cancels, the largest legal one.
		send_request(FUNC_INVERT_RECT, 2, 9, 22, 15, 1'b0);
		send_request(FUNC_INVERT_RECT, 0, 0, SCREEN_W, 5, 1'b0);
		send_request(FUNC_INVERT_RECT, 0, 0, 5, SCREEN_H, 1'b0);
		send_request(FUNC_READ_ROW, 0, 10, 0, 0, 1'b0);
		send_request(FUNC_INVERT_RECT, 0, 0, SCREEN_W - 1, SCREEN_H - 1, 1'b1);
		send_request(FUNC_READ_ROW, 0, SCREEN_H - 1, 0, 0, 1'b0);
		// Rows off screen read as zero bytes with the full count.
		send_request(FUNC_READ_ROW, 0, SCREEN_H, 0, 0, 1'b0);
		send_request(FUNC_READ_ROW, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		send_request(FUNC_READ_PIXEL, SCREEN_W - 2, SCREEN_H - 2, 0, 0, 1'b0);
		for (int f = FUNC_READ_ROW + 1; f <= FUNC_MAX; f++)
			send_request(FUNC_W'(f), 1, 1, 9, 9, 1'b1);
		send_request(FUNC_FILL_RECT, 0, 0, SCREEN_W, SCREEN_H, 1'b0);
		send_request(FUNC_READ_ROW, 0, 9, 0, 0, 1'b0);

		// Hold off until every outstanding read byte has come back.
		in_valid <= 1'b0;
		wait_reads_done();

		// Random traffic over four pacing phases.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 60;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 60;
			end
			default: begin
				idle_pct = 6;
				stall_pct = 6;
			end
			endcase
			run_random(RANDOM_REQUESTS / PHASES);
		end
		in_valid <= 1'b0;
		wait_reads_done();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d writes, %0d pixel reads, %0d fills, %0d inverts, %0d row reads",
			requests_by_func[FUNC_WRITE_PIXEL], requests_by_func[FUNC_READ_PIXEL],
			requests_by_func[FUNC_FILL_RECT], requests_by_func[FUNC_INVERT_RECT],
			requests_by_func[FUNC_READ_ROW]);
		$display("and checked %0d returned bytes under four idle and stall mixes.",
			sb.results_checked);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== mono_framebuffer_raster_engine.f =====
rtl/mfb_pkg.sv
rtl/mono_framebuffer_raster_engine.sv
dv/testbench.sv
